/* rtl/indexed_min_heap_core_macros.svh */
// Assertion macros for the indexed min-heap core.
`ifndef INDEXED_MIN_HEAP_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_CORE_MACROS_SVH
// Implication checked every clock, quiet during reset.
`define IMH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked every clock, quiet during reset.
`define IMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* rtl/imh_pkg.sv */
// Package with types, constants and codes of the indexed min-heap core.
`default_nettype none
package imh_pkg;
   localparam int CAPACITY   = 256;
   localparam int MAX_VERTEX = 1023;
   localparam int KEY_BITS   = 32;
   localparam int VTX_W      = 10;
   localparam int SLOT_W     = $clog2(CAPACITY + 1);
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int NVERT      = MAX_VERTEX + 1;
   localparam int VIDX_W     = $clog2(NVERT);

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_EXTRACT  = 2'd1;
   localparam logic [1:0] OP_DECREASE = 2'd2;
   localparam logic [1:0] OP_QUERY    = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_RANGE     = 3'd2;
   localparam logic [2:0] ST_ABSENT    = 3'd3;
   localparam logic [2:0] ST_LARGER    = 3'd4;
   localparam logic [2:0] ST_EMPTY     = 3'd5;
   localparam logic [2:0] ST_PRESENT   = 3'd6;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [VTX_W-1:0]    vertex;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [VTX_W-1:0]    out_vertex;
      logic [KEY_BITS-1:0] out_key;
      logic                present;
      logic [SLOT_W-1:0]   count;
   } rsp_type;

   // datapath commands
   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_LATCH    = 4'd1;  // set slot a from decoded request
   localparam logic [3:0] CMD_READ_A   = 4'd2;  // read heap at slot a
   localparam logic [3:0] CMD_READ_B   = 4'd3;  // read heap at slot b
   localparam logic [3:0] CMD_WRITE_A  = 4'd4;  // write held entry a to slot a
   localparam logic [3:0] CMD_WRITE_B  = 4'd5;  // write held entry b to slot a, advance a to b
   localparam logic [3:0] CMD_INS      = 4'd6;  // append new entry at count+1
   localparam logic [3:0] CMD_SETKEY   = 4'd7;  // a.key = request key
   localparam logic [3:0] CMD_CLRMAP   = 4'd8;  // mark vertex of a absent
   localparam logic [3:0] CMD_DEC_CNT  = 4'd9;
   localparam logic [3:0] CMD_SWAP     = 4'd10; // swap held entries a and b
   localparam logic [3:0] CMD_READ_C   = 4'd11; // read heap at second child
   localparam logic [3:0] CMD_PICK     = 4'd12; // choose smaller child into b
   localparam logic [3:0] CMD_CLEAR    = 4'd13; // clear one map row

   typedef struct packed {
      logic [3:0] cmd;
      logic       slot_from_map; // slot a taken from position map
      logic       up;            // slot b = parent of a, else left child
      logic       rsp;           // emit response
      logic [2:0] status;
   } ctl_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       in_range;
      logic       held;
      logic       full;
      logic       empty;
      logic       one_left;
      logic       larger;
      logic       at_root;
      logic       b_valid;
      logic       c_valid;
      logic       b_less;
      logic       a_less;
      logic       clear_done;
   } sts_type;
endpackage
`default_nettype wire

/* rtl/indexed_min_heap_core.sv */
// Indexed min-heap core (insert, extract-min, decrease-key, query): a
// request transfers when start is high and busy low; exactly one result
// follows, shown for one cycle with done high, and the receiver cannot
// stall it. After reset busy stays high while the position map is cleared
// row by row. A query or a rejected request passes through the decode and
// done states; its result shows as busy drops, and the next request may
// transfer in that same cycle. Insert and decrease take longer for each
// heap level climbed, extract for each level descended, through the heap
// memory read, compare and swap loop.
`default_nettype none
module indexed_min_heap_core import imh_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         done,
   output rsp_type      rsp_data
);
   ctl_type ctl;
   sts_type sts;
   logic    req_take;

   assign req_take = start && !busy;

   imh_controller u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_take (req_take),
      .sts      (sts),
      .ctl      (ctl),
      .busy     (busy)
   );

   imh_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .req_take   (req_take),
      .ctl        (ctl),
      .sts        (sts),
      .rsp        (rsp_data),
      .rsp_strobe (done)
   );
endmodule
`default_nettype wire

/* rtl/imh_datapath.sv */
// Datapath of the indexed min-heap core: heap memory, position map, holding registers.
`default_nettype none
module imh_datapath import imh_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req,
   input  wire logic    req_take,
   input  wire ctl_type ctl,
   output sts_type      sts,
   output rsp_type      rsp,
   output logic         rsp_strobe
);
   logic [VTX_W+KEY_BITS-1:0] heap_mem [CAPACITY];
   logic [SLOT_W-1:0]         map_mem  [NVERT];

   req_type                   req_ff;
   logic [SLOT_W-1:0]         count_ff, count_in;
   logic [SLOT_W-1:0]         sa_ff, sb_ff, sc_ff;
   logic [VTX_W-1:0]          va_ff, vb_ff, vc_ff;
   logic [KEY_BITS-1:0]       ka_ff, kb_ff, kc_ff;
   logic [SLOT_W-1:0]         map_rd_ff;
   logic [VIDX_W-1:0]         clr_ff;
   logic [VTX_W+KEY_BITS-1:0] rd_ff;
   logic [1:0]                rd_sel_ff;
   rsp_type                   rsp_ff;
   logic                      strobe_ff;
   logic [VTX_W-1:0]          out_v_ff;
   logic [KEY_BITS-1:0]       out_k_ff;

   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic               rd_en, wr_en;
   logic [VTX_W+KEY_BITS-1:0] wr_data;
   logic               map_we;
   logic [VIDX_W-1:0]  map_wa;
   logic [SLOT_W-1:0]  map_wd;
   logic [SLOT_W-1:0]  held_slot;

   assign held_slot = map_rd_ff;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = {va_ff, ka_ff};
      map_we  = 1'b0;
      map_wa  = '0;
      map_wd  = '0;
      case (ctl.cmd)
         CMD_READ_A: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(sa_ff - SLOT_W'(1));
         end
         CMD_READ_B: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(sb_ff - SLOT_W'(1));
         end
         CMD_READ_C: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(sc_ff - SLOT_W'(1));
         end
         CMD_WRITE_A: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(sa_ff - SLOT_W'(1));
            wr_data = {va_ff, ka_ff};
            map_we  = 1'b1;
            map_wa  = VIDX_W'(va_ff);
            map_wd  = sa_ff;
         end
         CMD_WRITE_B: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(sa_ff - SLOT_W'(1));
            wr_data = {vb_ff, kb_ff};
            map_we  = 1'b1;
            map_wa  = VIDX_W'(vb_ff);
            map_wd  = sa_ff;
         end
         CMD_INS: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(count_ff);
            wr_data = {req_ff.vertex, req_ff.key};
            map_we  = 1'b1;
            map_wa  = VIDX_W'(req_ff.vertex);
            map_wd  = count_ff + SLOT_W'(1);
         end
         CMD_CLRMAP: begin
            map_we  = 1'b1;
            map_wa  = VIDX_W'(va_ff);
            map_wd  = '0;
         end
         CMD_CLEAR: begin
            map_we  = 1'b1;
            map_wa  = clr_ff;
            map_wd  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) heap_mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= heap_mem[rd_addr];
      if (map_we) map_mem[map_wa] <= map_wd;
      if (req_take) map_rd_ff <= map_mem[VIDX_W'(req.vertex)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.cmd == CMD_CLEAR) begin
         clr_ff <= clr_ff + VIDX_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.cmd == CMD_INS) count_in = count_ff + SLOT_W'(1);
      else if (ctl.cmd == CMD_DEC_CNT) count_in = count_ff - SLOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         rd_sel_ff <= 2'd0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= ctl.rsp;
         rd_sel_ff <= (ctl.cmd == CMD_READ_A) ? 2'd1 :
                      (ctl.cmd == CMD_READ_B) ? 2'd2 :
                      (ctl.cmd == CMD_READ_C) ? 2'd3 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req;
      case (rd_sel_ff)
         2'd1: {va_ff, ka_ff} <= rd_ff;
         2'd2: {vb_ff, kb_ff} <= rd_ff;
         2'd3: {vc_ff, kc_ff} <= rd_ff;
         default: ;
      endcase
      case (ctl.cmd)
         CMD_LATCH: begin
            out_v_ff <= '0;
            out_k_ff <= '0;
            if (ctl.slot_from_map) sa_ff <= held_slot;
            else                   sa_ff <= SLOT_W'(1);
         end
         CMD_INS: begin
            sa_ff <= count_ff + SLOT_W'(1);
            va_ff <= req_ff.vertex;
            ka_ff <= req_ff.key;
         end
         CMD_SETKEY: ka_ff <= req_ff.key;
         CMD_CLRMAP: begin
            out_v_ff <= va_ff;
            out_k_ff <= ka_ff;
            sb_ff    <= count_ff;
            sa_ff    <= SLOT_W'(1);
         end
         CMD_SWAP: begin
            {va_ff, ka_ff, vb_ff, kb_ff} <= {vb_ff, kb_ff, va_ff, ka_ff};
         end
         CMD_PICK: begin
            if (sts.c_valid && kc_ff < kb_ff) begin
               sb_ff <= sc_ff;
               vb_ff <= vc_ff;
               kb_ff <= kc_ff;
            end
         end
         CMD_WRITE_A: begin
            if (ctl.up) begin
               sb_ff <= {1'b0, sa_ff[SLOT_W-1:1]};
            end else begin
               sb_ff <= {sa_ff[SLOT_W-2:0], 1'b0};
               sc_ff <= {sa_ff[SLOT_W-2:0], 1'b1};
            end
         end
         CMD_WRITE_B: begin
            // advance: the held entry a now belongs at slot b
            sa_ff <= sb_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp) begin
         rsp_ff.status     <= ctl.status;
         rsp_ff.out_vertex <= (ctl.status == ST_OK) ? out_v_ff : '0;
         rsp_ff.out_key    <= (ctl.status == ST_OK) ? out_k_ff : '0;
         rsp_ff.present    <= (req_ff.opcode == OP_QUERY) && (ctl.status == ST_OK) &&
                              sts.held;
         rsp_ff.count      <= count_ff;
      end
   end

   assign sts.opcode     = req_ff.opcode;
   assign sts.in_range   = {22'd0, req_ff.vertex} <= MAX_VERTEX;
   assign sts.held       = (held_slot != '0) && (held_slot <= count_ff);
   assign sts.full       = count_ff >= SLOT_W'(CAPACITY);
   assign sts.empty      = count_ff == '0;
   assign sts.one_left   = count_ff == SLOT_W'(1);
   assign sts.larger     = req_ff.key > ka_ff;
   assign sts.at_root    = sa_ff <= SLOT_W'(1);
   assign sts.b_valid    = ({1'b0, sa_ff} << 1) <= {1'b0, count_ff};
   assign sts.c_valid    = sc_ff <= count_ff;
   assign sts.b_less     = kb_ff < ka_ff;
   assign sts.a_less     = ka_ff < kb_ff;
   assign sts.clear_done = clr_ff == VIDX_W'(NVERT - 1);

   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;
endmodule
`default_nettype wire

/* rtl/imh_controller.sv */
// Controller state machine of the indexed min-heap core.
`default_nettype none
module imh_controller import imh_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_take,
   input  wire sts_type sts,
   output ctl_type      ctl,
   output logic         busy
);
`include "indexed_min_heap_core_macros.svh"
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DECODE = 5'd1;
   localparam logic [4:0] S_UP_W   = 5'd2;
   localparam logic [4:0] S_UP_RB  = 5'd3;
   localparam logic [4:0] S_UP_WB  = 5'd4;
   localparam logic [4:0] S_UP_LD  = 5'd5;
   localparam logic [4:0] S_UP_CMP = 5'd6;
   localparam logic [4:0] S_UP_SW  = 5'd7;
   localparam logic [4:0] S_UP_WR  = 5'd8;
   localparam logic [4:0] S_DK_RA  = 5'd9;
   localparam logic [4:0] S_DK_WT  = 5'd10;
   localparam logic [4:0] S_DK_LD  = 5'd11;
   localparam logic [4:0] S_DK_CMP = 5'd12;
   localparam logic [4:0] S_EX_RA  = 5'd13;
   localparam logic [4:0] S_EX_WT  = 5'd14;
   localparam logic [4:0] S_EX_LD  = 5'd15;
   localparam logic [4:0] S_EX_CLR = 5'd16;
   localparam logic [4:0] S_EX_RL  = 5'd17;
   localparam logic [4:0] S_EX_WL  = 5'd18;
   localparam logic [4:0] S_EX_LL  = 5'd19;
   localparam logic [4:0] S_DN_W   = 5'd20;
   localparam logic [4:0] S_DN_RB  = 5'd21;
   localparam logic [4:0] S_DN_RC  = 5'd22;
   localparam logic [4:0] S_DN_LB  = 5'd23;
   localparam logic [4:0] S_DN_LC  = 5'd24;
   localparam logic [4:0] S_DN_PK  = 5'd25;
   localparam logic [4:0] S_DN_CMP = 5'd26;
   localparam logic [4:0] S_DN_SW  = 5'd27;
   localparam logic [4:0] S_DONE   = 5'd28;
   localparam logic [4:0] S_CLEAR  = 5'd29;

   logic [4:0] state_ff, state_in;
   logic [2:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      ctl       = '0;
      case (state_ff)
         S_CLEAR: begin
            ctl.cmd = CMD_CLEAR;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: if (req_take) state_in = S_DECODE;
         S_DECODE: begin
            ctl.cmd = CMD_LATCH;
            ctl.slot_from_map = 1'b1;
            status_in = ST_OK;
            state_in  = S_DONE;
            case (sts.opcode)
               OP_INSERT: begin
                  if (sts.full) status_in = ST_FULL;
                  else if (!sts.in_range) status_in = ST_RANGE;
                  else if (sts.held) status_in = ST_PRESENT;
                  else state_in = S_UP_W;
               end
               OP_EXTRACT: begin
                  ctl.slot_from_map = 1'b0;
                  if (sts.empty) status_in = ST_EMPTY;
                  else state_in = S_EX_RA;
               end
               OP_DECREASE: begin
                  if (!sts.in_range) status_in = ST_RANGE;
                  else if (!sts.held) status_in = ST_ABSENT;
                  else state_in = S_DK_RA;
               end
               default: if (!sts.in_range) status_in = ST_RANGE;
            endcase
         end
         S_UP_W: begin
            ctl.cmd = CMD_INS;
            state_in = S_UP_WR;
         end
         S_DK_RA: begin ctl.cmd = CMD_READ_A; state_in = S_DK_WT; end
         S_DK_WT: state_in = S_DK_LD;
         S_DK_LD: state_in = S_DK_CMP;
         S_DK_CMP: begin
            if (sts.larger) begin
               status_in = ST_LARGER;
               state_in  = S_DONE;
            end else begin
               ctl.cmd  = CMD_SETKEY;
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            ctl.cmd = CMD_WRITE_A;
            ctl.up  = 1'b1;
            state_in = sts.at_root ? S_DONE : S_UP_RB;
         end
         S_UP_RB: begin ctl.cmd = CMD_READ_B; state_in = S_UP_WB; end
         S_UP_WB: state_in = S_UP_LD;
         S_UP_LD: state_in = S_UP_CMP;
         S_UP_CMP: state_in = sts.a_less ? S_UP_SW : S_DONE;
         S_UP_SW: begin
            ctl.cmd  = CMD_WRITE_B;
            state_in = S_UP_WR;
         end
         S_EX_RA: begin ctl.cmd = CMD_READ_A; state_in = S_EX_WT; end
         S_EX_WT: state_in = S_EX_LD;
         S_EX_LD: state_in = S_EX_CLR;
         S_EX_CLR: begin
            ctl.cmd = CMD_CLRMAP;
            state_in = S_EX_RL;
         end
         S_EX_RL: begin ctl.cmd = CMD_DEC_CNT; state_in = sts.one_left ? S_DONE : S_EX_WL; end
         S_EX_WL: begin ctl.cmd = CMD_READ_B; state_in = S_EX_LL; end
         S_EX_LL: state_in = S_DN_LB;
         S_DN_LB: begin ctl.cmd = CMD_SWAP; state_in = S_DN_W; end
         S_DN_W: begin
            ctl.cmd = CMD_WRITE_A;
            state_in = sts.b_valid ? S_DN_RB : S_DONE;
         end
         S_DN_RB: begin ctl.cmd = CMD_READ_B; state_in = S_DN_RC; end
         S_DN_RC: begin ctl.cmd = CMD_READ_C; state_in = S_DN_LC; end
         S_DN_LC: state_in = S_DN_PK;
         S_DN_PK: begin ctl.cmd = CMD_PICK; state_in = S_DN_CMP; end
         S_DN_CMP: state_in = sts.b_less ? S_DN_SW : S_DONE;
         S_DN_SW: begin
            ctl.cmd = CMD_WRITE_B;
            state_in = S_DN_W;
         end
         S_DONE: begin
            ctl.rsp    = 1'b1;
            ctl.status = status_ff;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   `IMH_ASSERT_NEXT(a_take_decode, clock, reset, req_take, state_ff == S_DECODE,
      "accepted request did not reach decode")
   `IMH_ASSERT_IMPL(a_rsp_done, clock, reset, ctl.rsp, state_ff == S_DONE,
      "response outside done state")
   `IMH_ASSERT_NEXT(a_done_idle, clock, reset, state_ff == S_DONE, !busy,
      "done state did not return to idle")
endmodule
`default_nettype wire

/* tb/tb_indexed_min_heap_core.sv */
// Testbench for the indexed min-heap core: directed table, random mixes, fill and drain.
`default_nettype none
module tb_indexed_min_heap_core;
   import imh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCH_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 200;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    done;
   rsp_type rsp_data;

   indexed_min_heap_core uut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .done(done), .rsp_data(rsp_data)
   );

   // predictor state
   logic [VTX_W-1:0]    heap_vtx [1:CAPACITY];
   logic [KEY_BITS-1:0] heap_key [1:CAPACITY];
   int                  slot_of [0:MAX_VERTEX];
   int                  entries;

   rsp_type  rsp_expected [$];
   row_type  dir_rows [$];
   int       errors;
   int       idle_cycles;
   bit       no_gaps;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report(input string field, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      errors++;
   endtask

   function automatic bit vtx_held(input int v);
      return slot_of[v] >= 1 && slot_of[v] <= entries;
   endfunction

   function automatic void swap_entries(input int a, input int b);
      logic [VTX_W-1:0]    tv;
      logic [KEY_BITS-1:0] tk;
      tv = heap_vtx[a]; tk = heap_key[a];
      heap_vtx[a] = heap_vtx[b]; heap_key[a] = heap_key[b];
      heap_vtx[b] = tv; heap_key[b] = tk;
      slot_of[heap_vtx[a]] = a;
      slot_of[heap_vtx[b]] = b;
   endfunction

   function automatic void climb(input int s);
      while (s > 1 && heap_key[s] < heap_key[s/2]) begin
         swap_entries(s, s/2);
         s = s / 2;
      end
   endfunction

   function automatic void descend(input int s);
      int best;
      forever begin
         best = s;
         if (2*s <= entries && heap_key[2*s] < heap_key[best]) best = 2*s;
         if (2*s+1 <= entries && heap_key[2*s+1] < heap_key[best]) best = 2*s+1;
         if (best == s) break;
         swap_entries(s, best);
         s = best;
      end
   endfunction

   function automatic rsp_type heap_apply(input req_type r);
      rsp_type o;
      int      v;
      int      s;
      o = '0;
      v = r.vertex;
      case (r.opcode)
         OP_INSERT: begin
            if (entries >= CAPACITY) o.status = ST_FULL;
            else if (v > MAX_VERTEX) o.status = ST_RANGE;
            else if (vtx_held(v)) o.status = ST_PRESENT;
            else begin
               entries++;
               heap_vtx[entries] = r.vertex;
               heap_key[entries] = r.key;
               slot_of[v] = entries;
               climb(entries);
            end
         end
         OP_EXTRACT: begin
            if (entries == 0) o.status = ST_EMPTY;
            else begin
               o.out_vertex = heap_vtx[1];
               o.out_key = heap_key[1];
               slot_of[heap_vtx[1]] = 0;
               if (entries > 1) begin
                  heap_vtx[1] = heap_vtx[entries];
                  heap_key[1] = heap_key[entries];
                  slot_of[heap_vtx[1]] = 1;
               end
               entries--;
               if (entries >= 1) descend(1);
            end
         end
         OP_DECREASE: begin
            if (v > MAX_VERTEX) o.status = ST_RANGE;
            else if (!vtx_held(v)) o.status = ST_ABSENT;
            else begin
               s = slot_of[v];
               if (r.key > heap_key[s]) o.status = ST_LARGER;
               else begin
                  heap_key[s] = r.key;
                  climb(s);
               end
            end
         end
         default: begin
            if (v > MAX_VERTEX) o.status = ST_RANGE;
            else o.present = vtx_held(v);
         end
      endcase
      o.count = entries[SLOT_W-1:0];
      return o;
   endfunction

   function automatic void add_row(input logic [1:0] op, input int v, input logic [31:0] k,
                                   input bit typed, input logic [2:0] st, input int cnt,
                                   input bit pres);
      row_type row;
      row.req = '{opcode: op, vertex: v[VTX_W-1:0], key: k};
      row.typed = typed;
      row.rsp = '0;
      row.rsp.status = st;
      row.rsp.present = pres;
      row.rsp.count = cnt[SLOT_W-1:0];
      dir_rows.push_back(row);
   endfunction

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 32'd0;
      if (r < 20) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic int pick_vertex(input bit prefer_held);
      if (prefer_held && entries > 0 && $urandom_range(99) < 70)
         return heap_vtx[$urandom_range(entries, 1)];
      if ($urandom_range(1)) return $urandom_range(31);
      return $urandom_range(MAX_VERTEX);
   endfunction

   function automatic req_type mixed_item();
      req_type r;
      int      op_roll;
      int      v;
      longint  cur;
      op_roll = $urandom_range(99);
      r.key = pick_key();
      if (op_roll < 35) begin
         r.opcode = OP_INSERT;
         v = pick_vertex($urandom_range(99) < 20);
      end else if (op_roll < 60) begin
         r.opcode = OP_EXTRACT;
         v = $urandom_range(MAX_VERTEX);
      end else if (op_roll < 85) begin
         r.opcode = OP_DECREASE;
         v = pick_vertex(1'b1);
         if (vtx_held(v)) begin
            cur = heap_key[slot_of[v]];
            case ($urandom_range(2))
               0: r.key = cur[31:0];
               1: r.key = 32'(longint'({$urandom, $urandom}) % (cur + 1));
               default: r.key = $urandom;
            endcase
         end
      end else begin
         r.opcode = OP_QUERY;
         v = pick_vertex(1'b1);
      end
      r.vertex = v[VTX_W-1:0];
      return r;
   endfunction

   task automatic send(input req_type r, input bit typed, input rsp_type want);
      rsp_type pred;
      while (!no_gaps && $urandom_range(99) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pred = heap_apply(r);
      rsp_expected.push_back(typed ? want : pred);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
   endtask

   // check each transfer on the result side
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((start && !busy) || done) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (done) begin
            if (rsp_expected.size() == 0) begin
               report("unexpected transfer", 1, 0);
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_data.status !== want.status)
                  report("status", rsp_data.status, want.status);
               if (rsp_data.out_vertex !== want.out_vertex)
                  report("out_vertex", rsp_data.out_vertex, want.out_vertex);
               if (rsp_data.out_key !== want.out_key)
                  report("out_key", rsp_data.out_key, want.out_key);
               if (rsp_data.present !== want.present)
                  report("present", rsp_data.present, want.present);
               if (rsp_data.count !== want.count)
                  report("count", rsp_data.count, want.count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("** indexed_min_heap_core: FAILED **");
         $finish;
      end
   end

   initial begin
      rsp_type none_rsp;
      int      v;
      req_type r;
      none_rsp = '0;
      errors = 0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      entries = 0;
      for (int i = 0; i <= MAX_VERTEX; i++) slot_of[i] = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;

      add_row(OP_EXTRACT, 0, 32'd0, 1, ST_EMPTY, 0, 0);
      add_row(OP_QUERY, 5, 32'd0, 1, ST_OK, 0, 0);
      add_row(OP_DECREASE, 7, 32'd1, 1, ST_ABSENT, 0, 0);
      add_row(OP_INSERT, 1023, 32'hFFFF_FFFF, 1, ST_OK, 1, 0);
      add_row(OP_INSERT, 1023, 32'd0, 1, ST_PRESENT, 1, 0);
      add_row(OP_QUERY, 1023, 32'd0, 1, ST_OK, 1, 1);
      add_row(OP_DECREASE, 1023, 32'hFFFF_FFFF, 1, ST_OK, 1, 0);
      add_row(OP_INSERT, 0, 32'd0, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 512, 32'd0, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 341, 32'd5, 0, ST_OK, 0, 0);
      add_row(OP_INSERT, 682, 32'd5, 0, ST_OK, 0, 0);
      add_row(OP_DECREASE, 682, 32'd6, 1, ST_LARGER, 5, 0);
      add_row(OP_DECREASE, 341, 32'd5, 0, ST_OK, 0, 0);
      add_row(OP_DECREASE, 1023, 32'd0, 0, ST_OK, 0, 0);
      add_row(OP_QUERY, 682, 32'd0, 0, ST_OK, 0, 0);
      for (int i = 0; i < 5; i++) add_row(OP_EXTRACT, 0, 32'd0, 0, ST_OK, 0, 0);
      add_row(OP_EXTRACT, 0, 32'd0, 1, ST_EMPTY, 0, 0);
      add_row(OP_QUERY, 0, 32'd0, 0, ST_OK, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      hold_until_drained();

      // mixed traffic, with a stretch of back-to-back transfers
      for (int i = 0; i < 100; i++) begin
         no_gaps = (i >= 40 && i < 80);
         send(mixed_item(), 0, none_rsp);
      end
      no_gaps = 1'b0;

      // fill to capacity, then push on a full heap
      v = $urandom_range(MAX_VERTEX);
      while (entries < CAPACITY) begin
         while (vtx_held(v)) v = (v + 1) % (MAX_VERTEX + 1);
         r = '{opcode: OP_INSERT, vertex: v[VTX_W-1:0], key: pick_key()};
         send(r, 0, none_rsp);
      end
      for (int i = 0; i < 4; i++) begin
         r = '{opcode: OP_INSERT, vertex: VTX_W'($urandom_range(MAX_VERTEX)), key: $urandom};
         send(r, 1, '{status: ST_FULL, out_vertex: '0, out_key: '0, present: 1'b0,
                      count: SLOT_W'(CAPACITY)});
      end
      for (int i = 0; i < 12; i++) begin
         r = mixed_item();
         if (r.opcode == OP_EXTRACT) r.opcode = OP_QUERY;
         send(r, 0, none_rsp);
      end
      hold_until_drained();

      // drain to empty and one past
      while (entries > 0) begin
         r = '{opcode: OP_EXTRACT, vertex: VTX_W'($urandom_range(MAX_VERTEX)), key: $urandom};
         send(r, 0, none_rsp);
      end
      send('{opcode: OP_EXTRACT, vertex: '0, key: '0}, 0, none_rsp);

      for (int i = 0; i < 40; i++) send(mixed_item(), 0, none_rsp);

      start <= 1'b0;
      @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("** indexed_min_heap_core: PASSED **");
      end else begin
         $display("** indexed_min_heap_core: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/imh_pkg.sv
rtl/imh_datapath.sv
rtl/imh_controller.sv
rtl/indexed_min_heap_core.sv
tb/tb_indexed_min_heap_core.sv
